>>> design/transducer_power_run_controller_unit_macros.svh
// Assertion macros shared by the transducer power run controller RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TRANSDUCER_POWER_RUN_CONTROLLER_UNIT_MACROS_SVH
`define TRANSDUCER_POWER_RUN_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TPRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tprc assertion failed");

// Next-cycle implication, checked out of reset.
`define TPRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tprc assertion failed");

`endif

>>> design/tprc_pkg.sv
// Types and constants of the transducer power run controller.
// Used by tprc_power_unit and transducer_power_run_controller_unit.
package tprc_pkg;

    localparam int unsigned CURRENT_W   = 10;
    localparam int unsigned PWM_HALF_W  = 9;
    localparam int unsigned PWM_W       = PWM_HALF_W + 1;
    localparam int unsigned POWER_W     = 14;
    localparam int unsigned TICKS_W     = 16;
    localparam int unsigned WIPER_W     = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam int unsigned POWER_DIVISOR = 1000;
    localparam int unsigned REM_W         = $clog2(POWER_DIVISOR);

    // The doubled PWM limit is 960, so the raw reading limit is 480.
    localparam logic [PWM_HALF_W-1:0] PWM_HALF_UPPER = 9'd480;
    localparam logic [WIPER_W-1:0]    WIPER_RESET    = 8'd30;
    localparam logic [POWER_W-1:0]    POWER_SAT      = 14'd16383;
    localparam logic [POWER_W-1:0]    SETPOINT_RESET = 14'd20;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_TURN_ON   = 3'd1,
        OP_TURN_OFF  = 3'd2,
        OP_ESTOP_SET = 3'd3,
        OP_ESTOP_CLR = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN_TIMED      = 2'd0,
        CFG_RUN_TICKS      = 2'd1,
        CFG_POWER_SETPOINT = 2'd2,
        CFG_HOLD_ENABLE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic start;
    } t_pwr_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_pwr_sts;

endpackage

>>> design/tprc_power_unit.sv
// Bit-serial power calculator: current * volts * (2 * pwm_half) / 1000, saturated.
// Depends on tprc_pkg and the macros header.
`include "transducer_power_run_controller_unit_macros.svh"

module tprc_power_unit #(
    parameter int unsigned DRIVE_VOLTS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tprc_pkg::t_pwr_ctl                  i_ctl,
    input  logic [tprc_pkg::CURRENT_W-1:0]      i_current_x10,
    input  logic [tprc_pkg::PWM_HALF_W-1:0]     i_pwm_half,
    output tprc_pkg::t_pwr_sts                  o_sts,
    output logic [tprc_pkg::POWER_W-1:0]        o_power
);

    localparam int unsigned VOLT_W = $clog2(DRIVE_VOLTS + 1);
    localparam int unsigned CV_W   = tprc_pkg::CURRENT_W + VOLT_W;
    localparam int unsigned ACC_W  = CV_W + tprc_pkg::PWM_W;
    localparam int unsigned CNT_W  = $clog2(ACC_W);
    localparam int unsigned REM_W  = tprc_pkg::REM_W;

    typedef enum logic [2:0] {
        P_IDLE = 3'b001,
        P_MUL  = 3'b010,
        P_DIV  = 3'b100
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic                         r_done, n_done;
    logic [CV_W-1:0]              r_cv, n_cv;
    logic [tprc_pkg::PWM_W-1:0]   r_mplr, n_mplr;
    logic [ACC_W-1:0]             r_acc, n_acc;
    logic [REM_W-1:0]             r_rem, n_rem;

    logic [REM_W:0]               w_trial;
    logic                         w_ge;

    // One long-division step: bring down the next dividend bit.
    assign w_trial = {r_rem, r_acc[ACC_W-1]};
    assign w_ge    = (w_trial >= (REM_W+1)'(tprc_pkg::POWER_DIVISOR));

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_cv    = r_cv;
        n_mplr  = r_mplr;
        n_acc   = r_acc;
        n_rem   = r_rem;
        unique case (r_phase)
            P_IDLE: begin
                if (i_ctl.start) begin
                    n_cv    = CV_W'(i_current_x10 * DRIVE_VOLTS);
                    n_mplr  = {i_pwm_half, 1'b0};
                    n_acc   = '0;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_phase = P_MUL;
                end
            end
            P_MUL: begin
                // Multiplier bits are taken MSB first.
                n_acc  = {r_acc[ACC_W-2:0], 1'b0}
                         + (r_mplr[tprc_pkg::PWM_W-1] ? ACC_W'(r_cv) : '0);
                n_mplr = {r_mplr[tprc_pkg::PWM_W-2:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(tprc_pkg::PWM_W - 1)) begin
                    n_cnt   = '0;
                    n_phase = P_DIV;
                end
            end
            P_DIV: begin
                // Quotient bits shift in at the bottom as dividend bits leave the top.
                n_rem = w_ge ? REM_W'(w_trial - (REM_W+1)'(tprc_pkg::POWER_DIVISOR))
                             : w_trial[REM_W-1:0];
                n_acc = {r_acc[ACC_W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    n_cnt   = '0;
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end
            end
            default: n_phase = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_cv   <= n_cv;
        r_mplr <= n_mplr;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
    end

    assign o_sts.busy = (r_phase != P_IDLE);
    assign o_sts.done = r_done;
    assign o_power    = (|r_acc[ACC_W-1:tprc_pkg::POWER_W]) ? tprc_pkg::POWER_SAT
                                                           : r_acc[tprc_pkg::POWER_W-1:0];

    `TPRC_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_ctl.start, r_phase == P_IDLE)
    `TPRC_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, r_phase == P_IDLE)
    `TPRC_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, r_phase == P_DIV, r_rem < REM_W'(tprc_pkg::POWER_DIVISOR))

endmodule

>>> design/transducer_power_run_controller_unit.sv
// Transducer power run controller: one command per input transaction, one status
// result per transaction. A tick occupies the block while tprc_power_unit runs its
// bit-serial multiply (10 steps) and divide by 1000 (one step per product bit, 24 at
// the default DRIVE_VOLTS); the other commands go straight to the output register.
// Input is stalled from acceptance until the result has entered the output register,
// which holds it while the output side stalls. Depends on tprc_pkg, tprc_power_unit
// and the macros header.
`include "transducer_power_run_controller_unit_macros.svh"

module transducer_power_run_controller_unit #(
    parameter int unsigned WIPER_MAX   = 127,
    parameter int unsigned DRIVE_VOLTS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [tprc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tprc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // command channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [2:0]                           i_op,
    input  logic [tprc_pkg::CURRENT_W-1:0]       i_current_x10,
    input  logic [tprc_pkg::PWM_HALF_W-1:0]      i_pwm_half,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_is_on,
    output logic                                 o_estop_active,
    output logic [tprc_pkg::POWER_W-1:0]         o_power_x10,
    output logic [tprc_pkg::TICKS_W-1:0]         o_ticks_left,
    output logic [tprc_pkg::WIPER_W-1:0]         o_wiper
);

    localparam int unsigned WIPER_W = tprc_pkg::WIPER_W;
    localparam int unsigned TICKS_W = tprc_pkg::TICKS_W;
    localparam int unsigned POWER_W = tprc_pkg::POWER_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_on, n_on;
    logic                            r_estop, n_estop;
    logic [TICKS_W-1:0]              r_cd, n_cd;
    logic [WIPER_W-1:0]              r_wiper, n_wiper;
    logic [POWER_W-1:0]              r_power, n_power;
    logic [tprc_pkg::PWM_HALF_W-1:0] r_pwm_half;

    logic                            r_run_timed;
    logic [TICKS_W-1:0]              r_run_ticks;
    logic [POWER_W-1:0]              r_setpoint;
    logic                            r_hold_en;

    logic                            r_out_valid, n_out_valid;
    logic                            r_out_on;
    logic                            r_out_estop;
    logic [POWER_W-1:0]              r_out_power;
    logic [TICKS_W-1:0]              r_out_ticks;
    logic [WIPER_W-1:0]              r_out_wiper;
    logic                            w_out_load;

    logic                            w_in_acc;
    tprc_pkg::t_pwr_ctl              w_pwr_ctl;
    tprc_pkg::t_pwr_sts              w_pwr_sts;
    logic [POWER_W-1:0]              w_unit_power;
    logic [TICKS_W-1:0]              w_cd_dec;
    logic                            w_on_tick;

    assign w_in_acc        = i_valid && (r_state == S_IDLE);
    assign w_pwr_ctl.start = w_in_acc && (tprc_pkg::t_op'(i_op) == tprc_pkg::OP_TICK);
    assign w_out_load      = (r_state == S_WAIT) && (!r_out_valid || !i_stall);

    tprc_power_unit #(
        .DRIVE_VOLTS (DRIVE_VOLTS)
    ) u_power (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_pwr_ctl),
        .i_current_x10 (i_current_x10),
        .i_pwm_half    (i_pwm_half),
        .o_sts         (w_pwr_sts),
        .o_power       (w_unit_power)
    );

    // A timed tick at zero count turns off instead of wrapping.
    assign w_cd_dec  = (r_cd == '0) ? '0 : r_cd - 1'b1;
    assign w_on_tick = !(r_on && r_run_timed && (w_cd_dec == '0)) && r_on;

    always_comb begin
        n_state = r_state;
        n_on    = r_on;
        n_estop = r_estop;
        n_cd    = r_cd;
        n_wiper = r_wiper;
        n_power = r_power;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_WAIT;
                    unique case (tprc_pkg::t_op'(i_op))
                        tprc_pkg::OP_TICK: n_state = S_CALC;
                        tprc_pkg::OP_TURN_ON: begin
                            if (!r_estop) begin
                                n_on = 1'b1;
                                if (r_run_timed) begin
                                    n_cd = r_run_ticks;
                                end
                            end
                        end
                        tprc_pkg::OP_TURN_OFF: begin
                            n_on = 1'b0;
                            n_cd = '0;
                        end
                        tprc_pkg::OP_ESTOP_SET: begin
                            n_estop = 1'b1;
                            n_on    = 1'b0;
                            n_cd    = '0;
                        end
                        tprc_pkg::OP_ESTOP_CLR: n_estop = 1'b0;
                        default: ;
                    endcase
                end
            end
            S_CALC: begin
                if (w_pwr_sts.done) begin
                    n_state = S_WAIT;
                    n_power = w_unit_power;
                    if (r_on && r_run_timed) begin
                        n_cd = w_cd_dec;
                    end
                    n_on = w_on_tick;
                    // Wiper steps toward the setpoint, held at the PWM and wiper limits.
                    if (r_hold_en && w_on_tick) begin
                        if (w_unit_power > r_setpoint) begin
                            if ((r_pwm_half != '0) && (r_wiper != '0)) begin
                                n_wiper = r_wiper - 1'b1;
                            end
                        end else if (w_unit_power < r_setpoint) begin
                            if ((r_pwm_half <= tprc_pkg::PWM_HALF_UPPER)
                                    && (r_wiper < WIPER_W'(WIPER_MAX))) begin
                                n_wiper = r_wiper + 1'b1;
                            end
                        end
                    end
                end
            end
            S_WAIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_on        <= 1'b0;
            r_estop     <= 1'b1;
            r_cd        <= '0;
            r_wiper     <= tprc_pkg::WIPER_RESET;
            r_power     <= '0;
            r_out_valid <= 1'b0;
            r_run_timed <= 1'b0;
            r_run_ticks <= '0;
            r_setpoint  <= tprc_pkg::SETPOINT_RESET;
            r_hold_en   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_on        <= n_on;
            r_estop     <= n_estop;
            r_cd        <= n_cd;
            r_wiper     <= n_wiper;
            r_power     <= n_power;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (tprc_pkg::t_cfg_idx'(i_cfg_idx))
                    tprc_pkg::CFG_RUN_TIMED:      r_run_timed <= i_cfg_data[0];
                    tprc_pkg::CFG_RUN_TICKS:      r_run_ticks <= i_cfg_data[TICKS_W-1:0];
                    tprc_pkg::CFG_POWER_SETPOINT: r_setpoint  <= i_cfg_data[POWER_W-1:0];
                    tprc_pkg::CFG_HOLD_ENABLE:    r_hold_en   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        if (w_pwr_ctl.start) begin
            r_pwm_half <= i_pwm_half;
        end
        if (w_out_load) begin
            r_out_on    <= r_on;
            r_out_estop <= r_estop;
            r_out_power <= r_power;
            r_out_ticks <= r_cd;
            r_out_wiper <= r_wiper;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_is_on        = r_out_on;
    assign o_estop_active = r_out_estop;
    assign o_power_x10    = r_out_power;
    assign o_ticks_left   = r_out_ticks;
    assign o_wiper        = r_out_wiper;

    `TPRC_ASSERT_IMP(a_estop_forces_off, i_clk, i_rst_n, r_estop, !r_on)
    `TPRC_ASSERT_NXT(a_tick_starts_calc, i_clk, i_rst_n, w_pwr_ctl.start, (r_state == S_CALC) && w_pwr_sts.busy)
    `TPRC_ASSERT_IMP(a_done_in_calc, i_clk, i_rst_n, w_pwr_sts.done, r_state == S_CALC)

endmodule

>>> test/transducer_power_run_controller_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for transducer_power_run_controller_unit: random and directed
// commands against a cycle-free model of the controller, with random idling on both sides.
// Depends on tprc_pkg and the controller RTL.
module transducer_power_run_controller_unit_tb;

    localparam int unsigned WIPER_MAX     = 127;
    localparam int unsigned DRIVE_VOLTS   = 12;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned QUIET_LIMIT   = 4000;
    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned PHASE_ITEMS   = 255;

    localparam int unsigned POWER_W    = tprc_pkg::POWER_W;
    localparam int unsigned TICKS_W    = tprc_pkg::TICKS_W;
    localparam int unsigned WIPER_W    = tprc_pkg::WIPER_W;
    localparam int unsigned CURRENT_W  = tprc_pkg::CURRENT_W;
    localparam int unsigned PWM_HALF_W = tprc_pkg::PWM_HALF_W;
    localparam int unsigned PWM_W      = tprc_pkg::PWM_W;
    localparam int unsigned CFG_IDX_W  = tprc_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = tprc_pkg::CFG_DATA_W;

    // Command codes outside the defined set; the controller must ignore them.
    localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_LAST  = 3'd7;

    typedef struct packed {
        logic               is_on;
        logic               estop;
        logic [POWER_W-1:0] power;
        logic [TICKS_W-1:0] ticks;
        logic [WIPER_W-1:0] wiper;
    } t_status;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [2:0]            i_op = '0;
    logic [CURRENT_W-1:0]  i_current_x10 = '0;
    logic [PWM_HALF_W-1:0] i_pwm_half = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_is_on;
    logic                  o_estop_active;
    logic [POWER_W-1:0]    o_power_x10;
    logic [TICKS_W-1:0]    o_ticks_left;
    logic [WIPER_W-1:0]    o_wiper;

    // Model of the controller state and its registers.
    logic               cfg_timed;
    logic [TICKS_W-1:0] cfg_run_ticks;
    logic [POWER_W-1:0] cfg_setpoint;
    logic               cfg_hold;
    logic               ctl_on;
    logic               ctl_estop;
    logic [TICKS_W-1:0] ctl_countdown;
    logic [WIPER_W-1:0] ctl_wiper;
    logic [POWER_W-1:0] ctl_power;

    t_status     pending_status[$];
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    transducer_power_run_controller_unit #(
        .WIPER_MAX   (WIPER_MAX),
        .DRIVE_VOLTS (DRIVE_VOLTS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_current_x10  (i_current_x10),
        .i_pwm_half     (i_pwm_half),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_on        (o_is_on),
        .o_estop_active (o_estop_active),
        .o_power_x10    (o_power_x10),
        .o_ticks_left   (o_ticks_left),
        .o_wiper        (o_wiper)
    );

    always #5 i_clk = ~i_clk;

    task automatic advance_controller(input logic [2:0] op, input logic [CURRENT_W-1:0] cur,
                                      input logic [PWM_HALF_W-1:0] pwm_half,
                                      output t_status status);
        logic [PWM_W-1:0] pwm;
        int unsigned      product;
        pwm = {pwm_half, 1'b0};
        case (tprc_pkg::t_op'(op))
            tprc_pkg::OP_TICK: begin
                product = int'(cur) * DRIVE_VOLTS * int'(pwm) / tprc_pkg::POWER_DIVISOR;
                ctl_power = (product > tprc_pkg::POWER_SAT) ? tprc_pkg::POWER_SAT
                                                            : product[POWER_W-1:0];
                // A countdown already at zero stops the output rather than wrapping.
                if (ctl_on && cfg_timed) begin
                    if (ctl_countdown != 0) ctl_countdown--;
                    if (ctl_countdown == 0) ctl_on = 1'b0;
                end
                if (cfg_hold && ctl_on) begin
                    if (ctl_power > cfg_setpoint) begin
                        if (pwm != 0 && ctl_wiper != 0) ctl_wiper--;
                    end else if (ctl_power < cfg_setpoint) begin
                        if (pwm_half <= tprc_pkg::PWM_HALF_UPPER && ctl_wiper < WIPER_MAX)
                            ctl_wiper++;
                    end
                end
            end
            tprc_pkg::OP_TURN_ON: begin
                if (!ctl_estop) begin
                    if (cfg_timed) ctl_countdown = cfg_run_ticks;
                    ctl_on = 1'b1;
                end
            end
            tprc_pkg::OP_TURN_OFF: begin
                ctl_on = 1'b0;
                ctl_countdown = '0;
            end
            tprc_pkg::OP_ESTOP_SET: begin
                ctl_estop = 1'b1;
                ctl_on = 1'b0;
                ctl_countdown = '0;
            end
            tprc_pkg::OP_ESTOP_CLR: ctl_estop = 1'b0;
            default: ;
        endcase
        status = '{ctl_on, ctl_estop, ctl_power, ctl_countdown, ctl_wiper};
    endtask

    // Tracks register writes and accepted commands, queuing the status each one must produce.
    always @(posedge i_clk) begin
        t_status next_status;
        if (!i_rst_n) begin
            cfg_timed     = 1'b0;
            cfg_run_ticks = '0;
            cfg_setpoint  = tprc_pkg::SETPOINT_RESET;
            cfg_hold      = 1'b0;
            ctl_on        = 1'b0;
            ctl_estop     = 1'b1;
            ctl_countdown = '0;
            ctl_wiper     = tprc_pkg::WIPER_RESET;
            ctl_power     = '0;
        end else begin
            if (i_cfg_we) begin
                case (tprc_pkg::t_cfg_idx'(i_cfg_idx))
                    tprc_pkg::CFG_RUN_TIMED:      cfg_timed = i_cfg_data[0];
                    tprc_pkg::CFG_RUN_TICKS:      cfg_run_ticks = i_cfg_data[TICKS_W-1:0];
                    tprc_pkg::CFG_POWER_SETPOINT: cfg_setpoint = i_cfg_data[POWER_W-1:0];
                    tprc_pkg::CFG_HOLD_ENABLE:    cfg_hold = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                advance_controller(i_op, i_current_x10, i_pwm_half, next_status);
                pending_status.push_back(next_status);
            end
        end
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_status.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result transaction: expected none, actual on=%0d",
                         $time, o_is_on);
            end else begin
                want = pending_status.pop_front();
                check_field("is_on", want.is_on, o_is_on);
                check_field("estop_active", want.estop, o_estop_active);
                check_field("power_x10", want.power, o_power_x10);
                check_field("ticks_left", want.ticks, o_ticks_left);
                check_field("wiper", want.wiper, o_wiper);
            end
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_left == 0 && hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_command(input logic [2:0] op, input logic [CURRENT_W-1:0] cur,
                                input logic [PWM_HALF_W-1:0] pwm_half);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_current_x10 <= cur;
        i_pwm_half    <= pwm_half;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic timed, input logic [TICKS_W-1:0] run_ticks,
                              input logic [POWER_W-1:0] setpoint, input logic hold);
        wait_for_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tprc_pkg::CFG_RUN_TIMED;
        i_cfg_data <= CFG_DATA_W'(timed);
        @(posedge i_clk);
        i_cfg_idx  <= tprc_pkg::CFG_RUN_TICKS;
        i_cfg_data <= CFG_DATA_W'(run_ticks);
        @(posedge i_clk);
        i_cfg_idx  <= tprc_pkg::CFG_POWER_SETPOINT;
        i_cfg_data <= CFG_DATA_W'(setpoint);
        @(posedge i_clk);
        i_cfg_idx  <= tprc_pkg::CFG_HOLD_ENABLE;
        i_cfg_data <= CFG_DATA_W'(hold);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Turn-on under emergency stop, field extremes and ignored command codes.
    task automatic test_commands();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_command(tprc_pkg::OP_TURN_ON, '0, '0);
        send_command(tprc_pkg::OP_ESTOP_CLR, '0, '0);
        send_command(tprc_pkg::OP_TURN_ON, '0, '0);
        send_command(tprc_pkg::OP_TICK, 10'd1023, 9'd511);
        send_command(tprc_pkg::OP_TICK, '0, '0);
        send_command(OP_UNKNOWN_FIRST, 10'd1023, 9'd511);
        send_command(OP_UNKNOWN_LAST, '0, '0);
        send_command(tprc_pkg::OP_TURN_ON, '0, '0);
        send_command(tprc_pkg::OP_TURN_OFF, '0, '0);
        send_command(tprc_pkg::OP_ESTOP_SET, '0, '0);
    endtask

    // Timed run: expiry, reload on a repeated turn-on, and a zero run count.
    task automatic test_timed_run();
        set_config(1'b1, 16'd2, tprc_pkg::SETPOINT_RESET, 1'b0);
        send_command(tprc_pkg::OP_ESTOP_CLR, '0, '0);
        send_command(tprc_pkg::OP_TURN_ON, '0, '0);
        send_command(tprc_pkg::OP_TICK, 10'd100, 9'd100);
        send_command(tprc_pkg::OP_TICK, 10'd100, 9'd100);
        send_command(tprc_pkg::OP_TURN_ON, '0, '0);
        send_command(tprc_pkg::OP_TICK, 10'd5, 9'd7);
        send_command(tprc_pkg::OP_TURN_ON, '0, '0);
        set_config(1'b1, 16'd0, tprc_pkg::SETPOINT_RESET, 1'b0);
        send_command(tprc_pkg::OP_TURN_ON, '0, '0);
        send_command(tprc_pkg::OP_TICK, 10'd1, 9'd1);
    endtask

    // Wiper stepping: up at the PWM limit, blocked just above it, down, and equal power.
    task automatic test_power_hold();
        set_config(1'b0, 16'hFFFF, tprc_pkg::POWER_SAT, 1'b1);
        send_command(tprc_pkg::OP_ESTOP_CLR, '0, '0);
        send_command(tprc_pkg::OP_TURN_ON, '0, '0);
        send_command(tprc_pkg::OP_TICK, 10'd1023, tprc_pkg::PWM_HALF_UPPER);
        send_command(tprc_pkg::OP_TICK, 10'd1023, tprc_pkg::PWM_HALF_UPPER + 9'd1);
        set_config(1'b0, 16'hFFFF, '0, 1'b1);
        send_command(tprc_pkg::OP_TICK, 10'd1023, 9'd511);
        send_command(tprc_pkg::OP_TICK, '0, '0);
    endtask

    // The result side holds off while commands keep coming, so the input stalls.
    task automatic test_backpressure();
        logic [2:0] op;
        set_config(1'b1, 16'd3, 14'd1500, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 14;
        hold_requests++;
        for (int n = 0; n < 24; n++) begin
            op = (n % 3 == 0) ? tprc_pkg::OP_TURN_ON
               : (n == 1) ? tprc_pkg::OP_ESTOP_CLR : tprc_pkg::OP_TICK;
            send_command(op, 10'($urandom_range(1023)), 9'($urandom_range(511)));
        end
    endtask

    task automatic test_random_phases();
        int unsigned          pick;
        logic [2:0]           op;
        logic [CURRENT_W-1:0] cur;
        logic [PWM_HALF_W-1:0] pwm_half;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_config(1'b1, 16'd5, '0, 1'b1);
                1: set_config(1'b0, 16'hFFFF, tprc_pkg::POWER_SAT, 1'b1);
                2: set_config(1'b1, 16'($urandom_range(30)), 14'($urandom_range(6000)), 1'b1);
                3: set_config(1'b1, 16'd0, tprc_pkg::SETPOINT_RESET, 1'b0);
                default: set_config(1'($urandom), 16'($urandom_range(30)),
                                    14'($urandom_range(16383)), 1'($urandom));
            endcase
            case (phase)
                0, 4: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                default: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Mostly ticks while running; stops and stray codes are the minority.
                pick = $urandom_range(99);
                if (pick < 70)      op = tprc_pkg::OP_TICK;
                else if (pick < 80) op = tprc_pkg::OP_TURN_ON;
                else if (pick < 83) op = tprc_pkg::OP_TURN_OFF;
                else if (pick < 86) op = tprc_pkg::OP_ESTOP_SET;
                else if (pick < 95) op = tprc_pkg::OP_ESTOP_CLR;
                else                op = 3'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
                cur = 10'($urandom_range(1023));
                pwm_half = 9'($urandom_range(511));
                if ($urandom_range(9) == 0) cur = $urandom_range(1) ? 10'd1023 : 10'd0;
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(3))
                        0: pwm_half = '0;
                        1: pwm_half = tprc_pkg::PWM_HALF_UPPER;
                        2: pwm_half = tprc_pkg::PWM_HALF_UPPER + 9'd1;
                        default: pwm_half = 9'd511;
                    endcase
                end
                send_command(op, cur, pwm_half);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_commands();
        test_timed_run();
        test_power_hold();
        test_random_phases();
        test_backpressure();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/tprc_pkg.sv
design/tprc_power_unit.sv
design/transducer_power_run_controller_unit.sv
test/transducer_power_run_controller_unit_tb.sv
